>>> sv/ccc_pkg.sv
// Shared types, constants and calendar functions for the calendar clock counter.
// No dependencies; every other file imports this package.

package ccc_pkg;

  localparam logic [10:0] MS_PER_SECOND   = 11'd1000;
  localparam logic [13:0] YEAR_LIMIT      = 14'd9999;
  localparam logic [10:0] MINUTES_PER_DAY = 11'd1440;
  localparam logic [10:0] MINUTES_PER_HOUR = 11'd60;
  localparam logic [5:0]  SECOND_MAX      = 6'd59;
  localparam logic [5:0]  MINUTE_MAX      = 6'd59;
  localparam logic [4:0]  HOUR_MAX        = 5'd23;
  localparam logic [3:0]  MONTH_MAX       = 4'd12;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
  } date_t;

  localparam date_t DATE_RESET = '{
    year: 14'd1, month: 4'd1, day: 5'd1, hour: 5'd0,
    minute: 6'd0, second: 6'd0, millisecond: 10'd0
  };

  typedef struct packed {
    opcode_t     opcode;
    logic [13:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
    logic [5:0]  load_second;
    logic [9:0]  load_millisecond;
  } in_word_t;

  typedef struct packed {
    logic [13:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
    logic [9:0]  cur_millisecond;
    logic        is_valid;
    logic        is_new_day;
    logic        is_new_year;
    logic        is_last_minute;
    logic [10:0] minutes_left;
  } out_word_t;

  function automatic logic [4:0] month_length(input logic [3:0] m);
    logic [4:0] len;
    if (m == 4'd2) begin
      len = 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

  function automatic logic date_valid(input date_t d);
    return (d.year != 14'd0) &&
           (d.month >= 4'd1) && (d.month <= MONTH_MAX) &&
           (d.day >= 5'd1) && (d.day <= month_length(d.month)) &&
           (d.hour <= HOUR_MAX) && (d.minute <= MINUTE_MAX) &&
           (d.second <= SECOND_MAX);
  endfunction

endpackage

>>> sv/ccc_tick.sv
// Millisecond tick: next date-time with carry through to the year.
// Year holds at 9999; an invalid date is held. Depends on ccc_pkg.

module ccc_tick
  import ccc_pkg::*;
(
  input  date_t cur,
  output date_t nxt
);

  logic [10:0] ms_inc;

  assign ms_inc = {1'b0, cur.millisecond} + 11'd1;

  always_comb begin
    nxt = cur;
    if (date_valid(cur)) begin
      if (ms_inc < MS_PER_SECOND) begin
        nxt.millisecond = ms_inc[9:0];
      end else begin
        nxt.millisecond = '0;
        if (cur.second != SECOND_MAX) begin
          nxt.second = cur.second + 6'd1;
        end else begin
          nxt.second = '0;
          if (cur.minute != MINUTE_MAX) begin
            nxt.minute = cur.minute + 6'd1;
          end else begin
            nxt.minute = '0;
            if (cur.hour != HOUR_MAX) begin
              nxt.hour = cur.hour + 5'd1;
            end else begin
              nxt.hour = '0;
              if (cur.day != month_length(cur.month)) begin
                nxt.day = cur.day + 5'd1;
              end else begin
                nxt.day = 5'd1;
                if (cur.month != MONTH_MAX) begin
                  nxt.month = cur.month + 4'd1;
                end else begin
                  nxt.month = 4'd1;
                  if (cur.year < YEAR_LIMIT) begin
                    nxt.year = cur.year + 14'd1;
                  end
                end
              end
            end
          end
        end
      end
    end
  end

endmodule

>>> sv/ccc_status.sv
// Result word: stored fields plus validity, day/year flags and minutes left.
// Depends on ccc_pkg.

module ccc_status
  import ccc_pkg::*;
(
  input  date_t     st,
  output out_word_t word
);

  logic [10:0] since;
  logic        new_day;

  assign since   = ({6'b0, st.hour} * MINUTES_PER_HOUR) + {5'b0, st.minute};
  assign new_day = (st.hour == 5'd0) && (st.minute == 6'd0) && (st.second == 6'd0);

  always_comb begin
    word.cur_year        = st.year;
    word.cur_month       = st.month;
    word.cur_day         = st.day;
    word.cur_hour        = st.hour;
    word.cur_minute      = st.minute;
    word.cur_second      = st.second;
    word.cur_millisecond = st.millisecond;
    word.is_valid        = date_valid(st);
    word.is_new_day      = new_day;
    word.is_new_year     = new_day && (st.month == 4'd1) && (st.day == 5'd1);
    word.is_last_minute  = (st.hour == HOUR_MAX) && (st.minute == MINUTE_MAX);
    if (new_day || (since > MINUTES_PER_DAY)) begin
      word.minutes_left = '0;
    end else begin
      word.minutes_left = MINUTES_PER_DAY - since;
    end
  end

endmodule

>>> sv/calendar_clock_counter.sv
// Top level of the calendar clock counter: input register, date-time state,
// result register. Depends on ccc_pkg, ccc_tick and ccc_status.
//
// Usage:
//   in_word carries one word per handshake: opcode OP_TICK advances the stored
//   date-time by one millisecond (only while it is valid), OP_LOAD stores the
//   load_ fields unchecked. A word is taken when in_valid is high and in_stall
//   is low.
//   out_word returns one result per input word, in order, under out_valid and
//   out_stall: the stored fields after that word and the status flags.
//   Path: a word taken is held in the input register, and its result is
//   registered into the result register when that register is free.
//   Throughput: one word per cycle while out_stall is low; the state update,
//   carry chain and flag logic sit in a single stage between the input and result registers.
//   Stall: while the result register holds an untaken word and out_stall is
//   high, the input register holds too and in_stall rises once it is full.
//   Reset (rst_n low at a clock edge): both registers empty, date-time set
//   to year 1, January 1, 00:00:00.000.

module calendar_clock_counter
  import ccc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      s1_valid_r;
  in_word_t  s1_word_r;
  date_t     state_r;
  date_t     state_nxt;
  date_t     ticked;
  date_t     loaded;
  logic      out_valid_r;
  out_word_t out_word_r;
  out_word_t out_word_nxt;
  logic      out_free;
  logic      advance;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  assign loaded = '{
    year: s1_word_r.load_year, month: s1_word_r.load_month,
    day: s1_word_r.load_day, hour: s1_word_r.load_hour,
    minute: s1_word_r.load_minute, second: s1_word_r.load_second,
    millisecond: s1_word_r.load_millisecond
  };

  ccc_tick u_tick (
    .cur (state_r),
    .nxt (ticked)
  );

  assign state_nxt = (s1_word_r.opcode == OP_LOAD) ? loaded : ticked;

  ccc_status u_status (
    .st   (state_nxt),
    .word (out_word_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= DATE_RESET;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_word_r <= in_word;
    end
    if (advance) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
